FILE: src/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SLT_ASSERT(name, clk_, rst_, prop, msg) \
  name: assert property (@(posedge clk_) disable iff (rst_) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SLT_ASSERT_ALWAYS(name, clk_, prop, msg) \
  name: assert property (@(posedge clk_) prop) else $error(msg);

`endif

FILE: src/slt_pkg.sv
// Shared types, constants and character classes of the shell line tokenizer.
`default_nettype none

package slt_pkg;

  localparam int MAX_LINE = 4096;
  localparam int START_W  = 12;
  localparam int LEN_W    = 13;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W    = $clog2(FIFO_DEPTH);
  localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);

  // Token kinds, plus the mode of an empty line.
  localparam logic [2:0] K_WS      = 3'd0;
  localparam logic [2:0] K_ATOM    = 3'd1;
  localparam logic [2:0] K_SYM     = 3'd2;
  localparam logic [2:0] K_STR     = 3'd3;
  localparam logic [2:0] K_COMMENT = 3'd4;
  localparam logic [2:0] K_PATH    = 3'd5;
  localparam logic [2:0] M_IDLE    = 3'd6;

  // Symbol join codes: what the open symbol may still absorb.
  localparam logic [2:0] PEND_NONE  = 3'd0;
  localparam logic [2:0] PEND_EQ    = 3'd1;
  localparam logic [2:0] PEND_BAR   = 3'd2;
  localparam logic [2:0] PEND_LT    = 3'd3;
  localparam logic [2:0] PEND_ASSIGN = 3'd4;

  // Quote tracking inside a string.
  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_INSIDE = 2'd1;
  localparam logic [1:0] Q_CLOSED = 2'd2;

  localparam logic [7:0] HIGH_BIT  = 8'h80;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef struct packed {
    logic [2:0]       mode;
    logic [1:0]       quote_phase;
    logic [2:0]       pending;
    logic [7:0]       prev_char;
    logic [START_W-1:0] token_begin;
    logic [LEN_W-1:0] line_pos;
    logic             overflowed;
  } lex_state_t;

  typedef struct packed {
    logic             ovf;
    logic             done;
    logic [2:0]       kind;
    logic [LEN_W-1:0] length;
    logic [START_W-1:0] start;
  } tok_t;

  localparam lex_state_t LEX_RESET = '{
    mode: M_IDLE, quote_phase: Q_NONE, pending: PEND_NONE, prev_char: 8'h00,
    token_begin: '0, line_pos: '0, overflowed: 1'b0};

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == 8'h0A) || (c == 8'h09) || (c == 8'h0D);
  endfunction

  function automatic logic is_sym(input logic [7:0] c, input logic in_word);
    logic r;
    r = 1'b0;
    unique case (c)
      "{", "}", "(", ")", "<", ">", "=", ";", "|", "^", "[", "]", ".": r = 1'b1;
      ":", "+": r = !in_word;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic word_byte(input logic [7:0] c, input logic [7:0] prev);
    logic r;
    r = 1'b1;
    if ((c & HIGH_BIT) != 8'h00) begin
      r = 1'b1;
    end else if (prev == CH_DOLLAR &&
                 (c == "^" || c == ":" || c == 8'h22 || c == CH_HASH)) begin
      r = 1'b1;
    end else if (is_space(c) || is_sym(c, 1'b1) || c == CH_QUOTE) begin
      r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [2:0] pair_code(input logic [7:0] c);
    logic [2:0] r;
    r = PEND_NONE;
    unique case (c)
      "=":      r = PEND_EQ;
      "|":      r = PEND_BAR;
      "<":      r = PEND_LT;
      ":", "+": r = PEND_ASSIGN;
      default:  r = PEND_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/slt_step.sv
// One byte step of the lexer: next state and the up to two tokens it reports.
`default_nettype none

module slt_step (
  input  slt_pkg::lex_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                eol,
  output slt_pkg::lex_state_t st_next,
  output logic                res0_valid,
  output slt_pkg::tok_t       res0,
  output logic                res1_valid,
  output slt_pkg::tok_t       res1
);
  import slt_pkg::*;

  localparam logic [LEN_W-1:0] LIMIT = LEN_W'(MAX_LINE);
  localparam logic [START_W-1:0] LAST_START = START_W'(MAX_LINE - 1);

  always_comb begin
    logic [LEN_W-1:0]   pos;
    logic [LEN_W-1:0]   lp_new;
    logic [START_W-1:0] at;
    logic [START_W-1:0] tb;
    logic               ovf;
    logic               ext;
    logic [2:0]         mode;
    logic [1:0]         qp;
    logic [2:0]         pend;

    mode = st.mode;
    qp   = st.quote_phase;
    pend = st.pending;
    tb   = st.token_begin;
    ovf  = st.overflowed;
    pos  = st.line_pos;
    if (pos >= LIMIT) begin
      ovf = 1'b1;
      pos = LIMIT;
    end
    at = (pos < LIMIT) ? pos[START_W-1:0] : LAST_START;

    // Does this byte extend the open token?
    ext = 1'b0;
    unique case (mode)
      K_WS: ext = is_space(in_byte);
      K_ATOM: begin
        if (word_byte(in_byte, st.prev_char)) begin
          ext = 1'b1;
          if (in_byte == CH_SLASH) mode = K_PATH;
        end
      end
      K_PATH: ext = !(is_space(in_byte) || in_byte == CH_HASH);
      K_SYM: begin
        if (pend == PEND_EQ || pend == PEND_BAR) begin
          ext = (in_byte == ">");
        end else if (pend == PEND_LT) begin
          ext = (in_byte == "<") || (in_byte == "=");
        end else if (pend == PEND_ASSIGN) begin
          ext = (in_byte == "=");
        end
        if (ext) pend = PEND_NONE;
      end
      K_STR: begin
        if (qp == Q_CLOSED) begin
          if (in_byte == CH_QUOTE) begin
            qp  = Q_INSIDE;
            ext = 1'b1;
          end
        end else begin
          ext = 1'b1;
          if (in_byte == CH_QUOTE) qp = Q_CLOSED;
        end
      end
      K_COMMENT: ext = 1'b1;
      default: ext = 1'b0;
    endcase

    res0_valid = 1'b0;
    res0       = '0;
    if (!ext) begin
      if (mode != M_IDLE) begin
        res0_valid  = 1'b1;
        res0.start  = st.token_begin;
        res0.length = pos - {1'b0, st.token_begin};
        res0.kind   = mode;
        res0.done   = 1'b0;
        res0.ovf    = ovf;
      end
      // The closing byte opens the next token.
      tb   = at;
      qp   = Q_NONE;
      pend = PEND_NONE;
      if (is_space(in_byte)) begin
        mode = K_WS;
      end else if (is_sym(in_byte, 1'b0)) begin
        mode = K_SYM;
        pend = pair_code(in_byte);
      end else if (in_byte == CH_HASH) begin
        mode = K_COMMENT;
      end else if (in_byte == CH_QUOTE) begin
        mode = K_STR;
        qp   = Q_INSIDE;
      end else if (in_byte == CH_SLASH) begin
        mode = K_PATH;
      end else begin
        mode = K_ATOM;
      end
    end

    lp_new = (pos < LIMIT) ? pos + LEN_W'(1) : LIMIT;

    res1_valid  = eol;
    res1.start  = tb;
    res1.length = lp_new - {1'b0, tb};
    res1.kind   = mode;
    res1.done   = 1'b1;
    res1.ovf    = ovf;

    if (eol) begin
      st_next = LEX_RESET;
    end else begin
      st_next.mode        = mode;
      st_next.quote_phase = qp;
      st_next.pending     = pend;
      st_next.prev_char   = in_byte;
      st_next.token_begin = tb;
      st_next.line_pos    = lp_new;
      st_next.overflowed  = ovf;
    end
  end

endmodule

`default_nettype wire

FILE: src/shell_line_tokenizer.sv
// Top level of the shell line tokenizer: lexer state and token output queue.
// Throughput: one byte per cycle while the four-entry token queue has room for
// two; a byte that reports two tokens needs two output transfers, the queue
// absorbing the extra one. A token is queued when its closing byte is accepted.
// Reset: rst clears the lexer to the no-token-open state and empties the queue.
`default_nettype none

module shell_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  // Input bytes of the line.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_line
  // Reported tokens.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [11:0] tok_start, [24:12] tok_length,
                                      // [27:25] tok_kind, [31:28] zero
  output logic        m_axis_tlast,   // line_done
  output logic        m_axis_tuser    // overflow
);
  import slt_pkg::*;

  // Lexer state. It only advances on an accepted input transfer; the line
  // position, token start and overflow flag live here as well.
  lex_state_t st;
  lex_state_t st_next;

  logic  res0_valid;
  logic  res1_valid;
  tok_t  res0;
  tok_t  res1;

  slt_step u_step (
    .st         (st),
    .in_byte    (s_axis_tdata),
    .eol        (s_axis_tlast),
    .st_next    (st_next),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1)
  );

  // Token queue. A byte adds at most two entries, so input is taken while
  // there is room for two, which also lets a byte in while a finished token
  // waits for the downstream side.
  tok_t             fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] n_wr;
  tok_t       wdata0;

  assign s_axis_tready = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Tokens are packed so that the first one reported goes into the first slot.
  assign n_wr   = in_fire ? ({1'b0, res0_valid} + {1'b0, res1_valid}) : 2'd0;
  assign wdata0 = res0_valid ? res0 : res1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= LEX_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) st <= st_next;
      wr_ptr <= wr_ptr + PTR_W'(n_wr);
      if (out_fire) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(n_wr) - CNT_W'(out_fire);
    end
  end

  // Queue storage carries payload only; the counters above say what is valid.
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) fifo[wr_ptr] <= wdata0;
    if (n_wr == 2'd2) fifo[wr_ptr + PTR_W'(1)] <= res1;
  end

  tok_t head;
  assign head = fifo[rd_ptr];

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {4'b0000, head.kind, head.length, head.start};
  assign m_axis_tlast  = head.done;
  assign m_axis_tuser  = head.ovf;

endmodule

`default_nettype wire

FILE: src/slt_checker.sv
// Port-level checks of the shell line tokenizer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module slt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import slt_pkg::*;

  // The end of a line always reports at least its final token.
  `SLT_ASSERT(a_eol_reports, clk, rst, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid, "end of line gave no token")

  // Every token is at least one byte long and has a defined kind.
  `SLT_ASSERT(a_tok_sane, clk, rst, m_axis_tvalid |-> (m_axis_tdata[24:12] != 13'd0) && (m_axis_tdata[27:25] <= K_PATH), "malformed token")

  // A stalled token keeps its contents.
  `SLT_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled token changed")

  // Reset empties the token queue.
  `SLT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "token pending after reset")

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
